// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define BMF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// clocked assertion, checked during reset too
`define BMF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== hw/rtl/bmf_pkg.sv =====
// types, codes and helpers for the button debounce menu block
`timescale 1ns / 1ps

package bmf_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PROGRAM = 2'd1,
        MODE_SAVE    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KEY_NONE    = 3'd0,
        KEY_PROGRAM = 3'd1,
        KEY_ENTER   = 3'd2,
        KEY_UP      = 3'd3,
        KEY_DOWN    = 3'd4
    } key_t;

    localparam int LINES_W   = 3;
    localparam int SAMPLES_W = 4;
    localparam int SLOPE_W   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_SAMPLES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_MIN        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_MAX        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_STEP       = 4'd3;

    localparam logic [SAMPLES_W-1:0] RST_DEBOUNCE_SAMPLES = 4'd3;
    localparam logic [SLOPE_W-1:0]   RST_SLOPE_MIN        = 8'd9;
    localparam logic [SLOPE_W-1:0]   RST_SLOPE_MAX        = 8'd20;
    localparam logic [SLOPE_W-1:0]   RST_SLOPE_STEP       = 8'd1;
    localparam logic [SLOPE_W-1:0]   RST_SLOPE            = 8'd10;

    localparam logic [LINES_W-1:0] LINES_ENTER   = 3'b001;
    localparam logic [LINES_W-1:0] LINES_UP      = 3'b010;
    localparam logic [LINES_W-1:0] LINES_DOWN    = 3'b100;
    localparam logic [LINES_W-1:0] LINES_PROGRAM = 3'b111;

    function automatic key_t decode_lines(input logic [LINES_W-1:0] lines);
        key_t k;
        unique case (lines)
            LINES_ENTER:   k = KEY_ENTER;
            LINES_UP:      k = KEY_UP;
            LINES_DOWN:    k = KEY_DOWN;
            LINES_PROGRAM: k = KEY_PROGRAM;
            default:       k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/bmf_debounce.sv =====
// debouncer: reports a key code once after enough equal samples
`timescale 1ns / 1ps

module bmf_debounce (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           sample_en,
    input  bmf_pkg::key_t                  code,
    input  logic [bmf_pkg::SAMPLES_W-1:0]  samples,
    output bmf_pkg::key_t                  key
);

    bmf_pkg::key_t                  last_reg, last_next;
    logic [bmf_pkg::SAMPLES_W-1:0]  count_reg, count_next;
    logic [bmf_pkg::SAMPLES_W-1:0]  count_inc;

    assign count_inc = count_reg + 1'b1;

    always_comb begin
        last_next  = last_reg;
        count_next = count_reg;
        key        = bmf_pkg::KEY_NONE;
        priority if (count_reg == '0 || code != last_reg) begin
            last_next  = code;
            count_next = {{(bmf_pkg::SAMPLES_W-1){1'b0}}, 1'b1};
        end else if (count_reg < samples) begin
            count_next = count_inc;
            if (count_inc == samples) begin
                key = code;
            end
        end else begin
            // key still held after the report
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= bmf_pkg::KEY_NONE;
            count_reg <= '0;
        end else if (sample_en) begin
            last_reg  <= last_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/button_debounce_menu_fsm.sv =====
// top level: input register, debounce and menu logic, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One scan tick enters per clock cycle while the input side is not stalled: the
// tick is captured in an input register, then decoded, debounced and applied
// to the menu state in one pass that loads the result register. The result
// register keeps a finished result while the next tick is accepted; the input
// side stalls only when both registers are full and the result is not taken.
// Configuration writes are always taken (cfg_ready high).
// m_axis_tdata holds, from bit 0: key_code[2:0], menu_mode[4:3], idle_lamp_on[5],
// program_led_on[6], slope_tenths[14:7], save_request[15].

module button_debounce_menu_fsm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bmf_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // pressed_lines[2:0], zero fill
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bmf_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // key_code, menu_mode, idle_lamp_on,
                                                             // program_led_on, slope_tenths,
                                                             // save_request
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [bmf_pkg::SAMPLES_W-1:0] samples_reg;
    logic [bmf_pkg::SLOPE_W-1:0]   slope_min_reg;
    logic [bmf_pkg::SLOPE_W-1:0]   slope_max_reg;
    logic [bmf_pkg::SLOPE_W-1:0]   slope_step_reg;

    logic                          in_valid_reg;
    logic [bmf_pkg::LINES_W-1:0]   lines_reg;
    logic                          out_valid_reg;
    logic [bmf_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    bmf_pkg::mode_t                mode_reg, mode_next;
    logic [bmf_pkg::SLOPE_W-1:0]   slope_reg, slope_next;

    logic                          advance;
    bmf_pkg::key_t                 code;
    bmf_pkg::key_t                 key;
    logic                          idle_led;
    logic                          prog_led;
    logic                          save_pulse;

    logic [bmf_pkg::SLOPE_W:0]     slope_sum;
    logic [bmf_pkg::SLOPE_W-1:0]   slope_up;
    logic [bmf_pkg::SLOPE_W-1:0]   slope_dn;
    logic [bmf_pkg::SLOPE_W-1:0]   slope_step_val;
    logic                          slope_borrow;

    // handshakes
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_reg    <= bmf_pkg::RST_DEBOUNCE_SAMPLES;
            slope_min_reg  <= bmf_pkg::RST_SLOPE_MIN;
            slope_max_reg  <= bmf_pkg::RST_SLOPE_MAX;
            slope_step_reg <= bmf_pkg::RST_SLOPE_STEP;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bmf_pkg::CFG_DEBOUNCE_SAMPLES: samples_reg <= cfg_data[bmf_pkg::SAMPLES_W-1:0];
                bmf_pkg::CFG_SLOPE_MIN:        slope_min_reg  <= cfg_data;
                bmf_pkg::CFG_SLOPE_MAX:        slope_max_reg  <= cfg_data;
                bmf_pkg::CFG_SLOPE_STEP:       slope_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            lines_reg <= s_axis_tdata[bmf_pkg::LINES_W-1:0];
        end
    end

    assign code = bmf_pkg::decode_lines(lines_reg);

    bmf_debounce u_debounce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sample_en (advance),
        .code      (code),
        .samples   (samples_reg),
        .key       (key)
    );

    // slope step with clamps, floor last
    assign slope_sum    = {1'b0, slope_reg} + {1'b0, slope_step_reg};
    assign slope_borrow = slope_reg < slope_step_reg;
    assign slope_step_val = slope_reg - slope_step_reg;

    always_comb begin
        if (slope_sum > {1'b0, slope_max_reg}) begin
            slope_up = slope_max_reg;
        end else begin
            slope_up = slope_sum[bmf_pkg::SLOPE_W-1:0];
        end
        if (slope_up < slope_min_reg) begin
            slope_up = slope_min_reg;
        end
        if (slope_borrow || slope_step_val < slope_min_reg) begin
            slope_dn = slope_min_reg;
        end else begin
            slope_dn = slope_step_val;
        end
    end

    // menu next state
    always_comb begin
        mode_next  = mode_reg;
        slope_next = slope_reg;
        unique case (mode_reg)
            bmf_pkg::MODE_IDLE: begin
                if (key == bmf_pkg::KEY_PROGRAM) begin
                    mode_next = bmf_pkg::MODE_PROGRAM;
                end
            end
            bmf_pkg::MODE_PROGRAM: begin
                if (key == bmf_pkg::KEY_UP) begin
                    slope_next = slope_up;
                end
                if (key == bmf_pkg::KEY_DOWN) begin
                    slope_next = slope_dn;
                end
                if (key == bmf_pkg::KEY_ENTER) begin
                    mode_next = bmf_pkg::MODE_SAVE;
                end
            end
            bmf_pkg::MODE_SAVE: begin
                mode_next = bmf_pkg::MODE_IDLE;
            end
            default: ;
        endcase
    end

    // menu outputs from the mode before the transition
    always_comb begin
        idle_led   = 1'b0;
        prog_led   = 1'b0;
        save_pulse = 1'b0;
        unique case (mode_reg)
            bmf_pkg::MODE_IDLE:    idle_led = 1'b1;
            bmf_pkg::MODE_PROGRAM: prog_led = 1'b1;
            bmf_pkg::MODE_SAVE: begin
                idle_led   = 1'b1;
                prog_led   = 1'b1;
                save_pulse = 1'b1;
            end
            default: ;
        endcase
    end

    assign out_data_next = {save_pulse, slope_next, prog_led, idle_led, mode_next, key};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= bmf_pkg::MODE_IDLE;
            slope_reg <= bmf_pkg::RST_SLOPE;
        end else if (advance) begin
            mode_reg  <= mode_next;
            slope_reg <= slope_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    `BMF_ASSERT(a_save_returns_idle, aclk, aresetn,
        (advance && mode_reg == bmf_pkg::MODE_SAVE) |=> (mode_reg == bmf_pkg::MODE_IDLE))
    `BMF_ASSERT(a_slope_floor, aclk, aresetn,
        (advance && mode_reg == bmf_pkg::MODE_PROGRAM
         && (key == bmf_pkg::KEY_UP || key == bmf_pkg::KEY_DOWN))
        |=> (slope_reg >= $past(slope_min_reg)))
    `BMF_ASSERT(a_stall_only_when_full, aclk, aresetn,
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))

endmodule
